// ===== sv/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CDQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cdq_pkg.sv =====
// Shared types, constants and index helpers for the circular deque.
package cdq_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic step;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_cmd;
    logic empty;
    logic full;
  } dp_stat_t;

  function automatic idx_t next_idx(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t prev_idx(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

endpackage

// ===== sv/cdq_in_if.sv =====
// Command channel: valid/ready with command and push word.
interface cdq_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

// ===== sv/cdq_out_if.sv =====
// Result channel: valid/ready with popped word, status and flags.
interface cdq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic               now_empty;
  logic               now_full;

  modport source (output valid, output popped_value, output status,
                  output now_empty, output now_full, input ready);
  modport sink (input valid, input popped_value, input status,
                input now_empty, input now_full, output ready);
endinterface

// ===== sv/cdq_ctrl.sv =====
// Handshake controller: accepts beats, sequences pop reads, owns out valid.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    in_ready       = (state == ST_IDLE) && (!out_valid || out_ready);
    ctl.step       = in_valid && in_ready;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (ctl.step) begin
          if (stat.pop_cmd) begin
            state_next = ST_READ;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_READ: begin
        // read data lands this cycle; result goes out
        state_next     = ST_IDLE;
        out_valid_next = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`include "assert_macros.svh"

  `CDQ_ASSERT_NEXT(a_read_then_result, state == ST_READ, out_valid && state == ST_IDLE, "pop result not presented after read")
  `CDQ_ASSERT_NEXT(a_push_result, ctl.step && !stat.pop_cmd, out_valid && state == ST_IDLE, "push result not presented")
  `CDQ_ASSERT_SAME(a_no_accept_in_read, state == ST_READ, !ctl.step && !out_valid, "beat accepted during read")
  `CDQ_ASSERT_SAME(a_flags_apart, stat.empty, !stat.full, "deque flagged empty and full")

endmodule

// ===== sv/cdq_datapath.sv =====
// Deque datapath: ring memory, front/back indices, empty flag, result register.
module cdq_datapath
  import cdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    ctl,
  input  logic [1:0]  cmd,
  input  word_t       value,
  output dp_stat_t    stat,
  output word_t       popped_value,
  output logic [1:0]  status,
  output logic        now_empty,
  output logic        now_full
);

  word_t   ring_mem [DEPTH];
  word_t   rd_data;

  idx_t    front, back;
  logic    is_empty;
  idx_t    front_next, back_next;
  logic    is_empty_next;
  logic    is_full;

  logic    wr_en, rd_en;
  idx_t    wr_addr, rd_addr;
  status_t res_status, out_status;
  logic    pop_ok, out_pop_ok;
  logic    out_empty, out_full;
  logic    full_next;
  cmd_t    op;

  assign op      = cmd_t'(cmd);
  assign is_full = !is_empty && (next_idx(back) == front);

  assign stat.pop_cmd = (op == CMD_POP_FRONT) || (op == CMD_POP_BACK);
  assign stat.empty   = is_empty;
  assign stat.full    = is_full;

  always_comb begin
    front_next    = front;
    back_next     = back;
    is_empty_next = is_empty;
    wr_en         = 1'b0;
    wr_addr       = '0;
    rd_en         = 1'b0;
    rd_addr       = front;
    res_status    = STAT_OK;
    pop_ok        = 1'b0;
    if (ctl.step) begin
      unique case (op)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (is_full) begin
            res_status = STAT_FULL;
          end else if (is_empty) begin
            front_next    = '0;
            back_next     = '0;
            is_empty_next = 1'b0;
            wr_en         = 1'b1;
            wr_addr       = '0;
          end else if (op == CMD_PUSH_FRONT) begin
            front_next = prev_idx(front);
            wr_en      = 1'b1;
            wr_addr    = prev_idx(front);
          end else begin
            back_next = next_idx(back);
            wr_en     = 1'b1;
            wr_addr   = next_idx(back);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (is_empty) begin
            res_status = STAT_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = (op == CMD_POP_FRONT) ? front : back;
            pop_ok  = 1'b1;
            if (front == back) begin
              // last word leaves: back to the reset layout
              front_next    = '0;
              back_next     = '0;
              is_empty_next = 1'b1;
            end else if (op == CMD_POP_FRONT) begin
              front_next = next_idx(front);
            end else begin
              back_next = prev_idx(back);
            end
          end
        end
        default: res_status = STAT_OK;
      endcase
    end
  end

  assign full_next = !is_empty_next && (next_idx(back_next) == front_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      back     <= '0;
      is_empty <= 1'b1;
    end else begin
      front    <= front_next;
      back     <= back_next;
      is_empty <= is_empty_next;
    end
  end

  // result fields; loaded on every accepted beat
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_status <= res_status;
      out_pop_ok <= pop_ok;
      out_empty  <= is_empty_next;
      out_full   <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  assign popped_value = out_pop_ok ? rd_data : '0;
  assign status       = out_status;
  assign now_empty    = out_empty;
  assign now_full     = out_full;

`include "assert_macros.svh"

  `CDQ_ASSERT_SAME(a_empty_layout, is_empty, front == '0 && back == '0, "empty deque with nonzero index")
  `CDQ_ASSERT_NEXT(a_refused_no_change, ctl.step && res_status != STAT_OK, $stable(front) && $stable(back) && $stable(is_empty), "refused command changed state")
  `CDQ_ASSERT_NEXT(a_pop_ok_status, ctl.step && pop_ok, out_pop_ok && out_status == STAT_OK, "successful pop without ok status")

endmodule

// ===== sv/circular_deque_core.sv =====
// Top level of the circular deque: controller plus datapath on two channels.
// A push, accepted or refused, gives its result beat in the cycle after
// acceptance; every pop, refused ones included, goes through the
// controller's read state first, and no command is taken in that state.
// Throughput: one push per cycle while the result side is ready.
// Synchronous reset empties the deque (indices zero); ring contents are not cleared.
module circular_deque_core
  import cdq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  cdq_in_if.sink    cmd_ch,
  cdq_out_if.source res_ch
);

  // control handshake between the two halves
  ctl_cmd_t ctl;
  dp_stat_t stat;

  // controller: decides when a beat is taken and when a result is shown
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // datapath: ring memory, indices and the result register
  cdq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd_ch.cmd),
    .value        (cmd_ch.value),
    .stat         (stat),
    .popped_value (res_ch.popped_value),
    .status       (res_ch.status),
    .now_empty    (res_ch.now_empty),
    .now_full     (res_ch.now_full)
  );

endmodule

// ===== tb/sv/cdq_checker.sv =====
// Deque checker: mirrors the deque, predicts each result beat and compares it.
module cdq_checker
  import cdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cdq_in_if    cmd_ch,
  cdq_out_if   res_ch,
  output int   mismatches,
  output int   waiting,
  output int   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t   popped;
    status_t status;
    logic    empty;
    logic    full;
  } deque_result_t;

  deque_result_t expected_q[$];

  // shadow deque
  word_t ring_shadow [DEPTH];
  idx_t  head_idx;
  idx_t  tail_idx;
  logic  shadow_empty;

  int errors_n  = 0;
  int results_n = 0;

  function automatic idx_t step_up(idx_t i);
    return idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic idx_t step_down(idx_t i);
    return idx_t'((int'(i) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic logic shadow_full();
    return !shadow_empty && (step_up(tail_idx) == head_idx);
  endfunction

  // apply one command to the shadow deque, return the beat it should give
  function automatic deque_result_t apply_command(cmd_t op, word_t w);
    deque_result_t r;
    idx_t slot;
    r.popped = '0;
    r.status = STAT_OK;
    if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
      if (shadow_full()) begin
        r.status = STAT_FULL;
      end else if (shadow_empty) begin
        head_idx = '0;
        tail_idx = '0;
        shadow_empty = 1'b0;
        ring_shadow[0] = w;
      end else if (op == CMD_PUSH_FRONT) begin
        head_idx = step_down(head_idx);
        ring_shadow[head_idx] = w;
      end else begin
        tail_idx = step_up(tail_idx);
        ring_shadow[tail_idx] = w;
      end
    end else if (shadow_empty) begin
      r.status = STAT_EMPTY;
    end else begin
      slot = (op == CMD_POP_FRONT) ? head_idx : tail_idx;
      r.popped = ring_shadow[slot];
      if (head_idx == tail_idx) begin
        head_idx = '0;
        tail_idx = '0;
        shadow_empty = 1'b1;
      end else if (op == CMD_POP_FRONT) begin
        head_idx = step_up(head_idx);
      end else begin
        tail_idx = step_down(tail_idx);
      end
    end
    r.empty = shadow_empty;
    r.full  = shadow_full();
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t want;
    if (rst) begin
      head_idx = '0;
      tail_idx = '0;
      shadow_empty = 1'b1;
      expected_q.delete();
    end else begin
      // result side first: a beat accepted this edge cannot belong to a
      // command accepted on the same edge
      if (res_ch.valid && res_ch.ready) begin
        results_n++;
        if (expected_q.size() == 0) begin
          $error("result beat with no command outstanding");
          errors_n++;
        end else begin
          want = expected_q.pop_front();
          if (res_ch.popped_value !== want.popped) begin
            $error("popped_value: expected %0d, got %0d", want.popped, res_ch.popped_value);
            errors_n++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_ch.status);
            errors_n++;
          end
          if (res_ch.now_empty !== want.empty) begin
            $error("now_empty: expected %0b, got %0b", want.empty, res_ch.now_empty);
            errors_n++;
          end
          if (res_ch.now_full !== want.full) begin
            $error("now_full: expected %0b, got %0b", want.full, res_ch.now_full);
            errors_n++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready)
        expected_q.push_back(apply_command(cmd_t'(cmd_ch.cmd), cmd_ch.value));
    end
    mismatches   <= errors_n;
    waiting      <= expected_q.size();
    results_seen <= results_n;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: clock, reset, command stimulus, result backpressure, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdq_pkg::*;

  localparam int ITEM_GOAL  = 1225;  // directed plus random commands
  localparam int QUIET_FROM = 1050;  // no idling on either side after this

  // fill up to capacity, churn around the level, drain to empty, churn
  typedef enum int {FILL_UP, CHURN, DRAIN_OUT} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdq_in_if  cmd_ch();
  cdq_out_if res_ch();

  int fail_count;
  int pending_count;
  int checked_count;

  // stimulus-side bookkeeping; steers the command mix and idling and feeds the final report
  int sent          = 0;
  int fill_level    = 0;
  int refused_push  = 0;
  int refused_pop   = 0;
  int times_full    = 0;
  bit src_idle_on   = 1'b0;
  bit sink_idle_on  = 1'b0;
  int sink_stall_left = 0;

  circular_deque_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  cdq_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cmd_ch       (cmd_ch),
    .res_ch       (res_ch),
    .mismatches   (fail_count),
    .waiting      (pending_count),
    .results_seen (checked_count)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result-side backpressure: ready drops in bursts while idling is enabled,
  // and stays high through the quiet tail of the run.
  always @(negedge clk) begin
    if (sink_stall_left > 0) begin
      sink_stall_left <= sink_stall_left - 1;
      res_ch.ready    <= 1'b0;
    end else if (sink_idle_on && sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
      sink_stall_left <= $urandom_range(0, 6);
      res_ch.ready    <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Corner words often, otherwise a full random 32-bit word.
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return word_t'(32'h8000_0000);
      1:       return word_t'(32'h7fff_ffff);
      2:       return word_t'(32'hffff_ffff);
      3:       return word_t'(32'h0000_0000);
      default: return word_t'($urandom);
    endcase
  endfunction

  // push_pct percent pushes, the rest pops; end picked at random
  function automatic cmd_t pick_command(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return ($urandom_range(0, 1) != 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    return ($urandom_range(0, 1) != 0) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  // One command beat. An optional idle gap with valid low goes first; valid
  // then stays high until the beat is taken at a rising edge.
  task automatic send_command(input cmd_t op, input word_t w);
    int gap;
    if (src_idle_on && sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= op;
    cmd_ch.value <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    sent++;
    // occupancy as the deque sees it, to steer the next commands
    if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
      if (fill_level == DEPTH) begin
        refused_push++;
      end else begin
        fill_level++;
        if (fill_level == DEPTH) times_full++;
      end
    end else if (fill_level == 0) begin
      refused_pop++;
    end else begin
      fill_level--;
    end
  endtask

  initial begin
    phase_t phase;
    int round;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = CMD_POP_FRONT;
    cmd_ch.value = '0;
    res_ch.ready = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: pops on an empty deque, a push onto empty then popping the
    // last word, front index wrapping below zero, extremes of the word and
    // alternating bit patterns, and a final drain back to empty.
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_command(CMD_POP_FRONT,  word_t'(32'h1234_5678));
    send_command(CMD_POP_BACK,   word_t'(32'hffff_ffff));
    send_command(CMD_PUSH_FRONT, word_t'(32'h8000_0000));
    send_command(CMD_POP_BACK,   word_t'(32'h0000_0000));
    send_command(CMD_PUSH_BACK,  word_t'(32'h7fff_ffff));
    send_command(CMD_PUSH_FRONT, word_t'(32'hffff_ffff));  // front wraps to top
    send_command(CMD_PUSH_BACK,  word_t'(32'h0000_0000));
    send_command(CMD_PUSH_FRONT, word_t'(32'h5555_5555));
    send_command(CMD_PUSH_BACK,  word_t'(32'haaaa_aaaa));
    send_command(CMD_POP_FRONT,  word_t'(32'h0000_0000));
    send_command(CMD_POP_BACK,   word_t'(32'h0000_0000));
    send_command(CMD_POP_FRONT,  word_t'(32'h0000_0000));
    send_command(CMD_POP_BACK,   word_t'(32'h0000_0000));
    send_command(CMD_POP_FRONT,  word_t'(32'h0000_0000));  // last word out
    send_command(CMD_POP_BACK,   word_t'(32'h0000_0000));  // empty again
    send_command(CMD_PUSH_FRONT, word_t'(32'h8000_0001));
    send_command(CMD_PUSH_BACK,  word_t'(32'h7fff_fffe));
    send_command(CMD_POP_FRONT,  word_t'(32'h0000_0000));
    send_command(CMD_POP_FRONT,  word_t'(32'h0000_0000));

    // Random: rotate fill / churn / drain / churn so both the full and the
    // empty boundary are hit repeatedly with indices wrapping around the ring.
    round = 0;
    while (sent < ITEM_GOAL) begin
      case (round % 4)
        0:       phase = FILL_UP;
        2:       phase = DRAIN_OUT;
        default: phase = CHURN;
      endcase
      // idling is chosen per phase so some stretches run back to back
      src_idle_on  = ($urandom_range(0, 9) < 7);
      sink_idle_on = ($urandom_range(0, 9) < 7);
      case (phase)
        FILL_UP: begin
          while (fill_level < DEPTH && sent < ITEM_GOAL)
            send_command(pick_command(85), pick_word());
          repeat ($urandom_range(1, 4)) send_command(pick_command(100), pick_word());
        end
        DRAIN_OUT: begin
          while (fill_level > 0 && sent < ITEM_GOAL)
            send_command(pick_command(15), pick_word());
          repeat ($urandom_range(1, 4)) send_command(pick_command(0), pick_word());
        end
        default: begin
          repeat ($urandom_range(20, 80)) send_command(pick_command(50), pick_word());
        end
      endcase
      round++;
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;

    // drain: every predicted beat must come back, then the bench waits on
    // to catch anything extra the block might still emit
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d commands, %0d result beats compared, deque filled %0d times",
             sent, checked_count, times_full);
    $display("run: %0d pushes refused on a full deque, %0d pops refused on an empty one",
             refused_push, refused_pop);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
